// ===== design/nwld_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nwld_pkg
// Shared types and constants of the noise weighted lottery draw unit.
// ----------------------------------------------------------------------------
package nwld_pkg;

  // table geometry
  localparam int TABLE_DEPTH = 64;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int WEIGHT_W    = 16;
  localparam int CNT_W       = 7;
  localparam int SMP_CNT_W   = 3;

  // input opcodes
  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  // scaling: drawn = floor((raw*m + 32767) / 65535)
  localparam logic [31:0] ROUND_HALF = 32'd32767;
  localparam logic [SMP_CNT_W-1:0] LAST_SAMPLE = 3'd7;
  localparam logic [CNT_W-1:0] LIMIT_MAX = CNT_W'(TABLE_DEPTH);

  typedef struct packed {
    logic                opcode;
    logic [IDX_W-1:0]    entry_index;
    logic [WEIGHT_W-1:0] entry_weight;
    logic [9:0]          noise_sample;
    logic [WEIGHT_W-1:0] total_weight;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]    winner_index;
    logic [WEIGHT_W-1:0] drawn_value;
    logic                matched;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_WSETUP,
    ST_WALK,
    ST_EMIT
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic mul;
    logic div;
    logic walk_init;
    logic walk_step;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic draw_go;
    logic limit_zero;
    logic walk_hit;
    logic walk_last;
  } sts_t;

endpackage

// ===== design/nwld_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nwld_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module nwld_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== design/nwld_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nwld_ctrl
// Sequencer of the draw: multiply, divide, table walk and result strobe.
// ----------------------------------------------------------------------------
module nwld_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  nwld_pkg::sts_t sts,
  output nwld_pkg::cmd_t cmd,
  output logic          busy,
  output logic          cfg_ready,
  output logic          out_valid
);
  import nwld_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = 1'b1;
    cfg_ready = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        busy       = 1'b0;
        cfg_ready  = 1'b1;
        cmd.accept = start;
        if (sts.draw_go) begin
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        cmd.div   = 1'b1;
        state_nxt = ST_WSETUP;
      end
      ST_WSETUP: begin
        cmd.walk_init = 1'b1;
        state_nxt     = sts.limit_zero ? ST_EMIT : ST_WALK;
      end
      ST_WALK: begin
        cmd.walk_step = 1'b1;
        if (sts.walk_hit || sts.walk_last) begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        out_valid = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== design/nwld_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nwld_dp
// Datapath: noise packing, scaling multiply, divide by 65535 and walk.
// ----------------------------------------------------------------------------
module nwld_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  nwld_pkg::in_item_t         in_item,
  input  nwld_pkg::cmd_t             cmd,
  input  logic                       cfg_we,
  input  logic [nwld_pkg::CNT_W-1:0] cfg_data,
  output nwld_pkg::sts_t             sts,
  output nwld_pkg::out_item_t        out_item
);
  import nwld_pkg::*;

  logic [WEIGHT_W-1:0]  acc_r, acc_nxt;
  logic [SMP_CNT_W-1:0] smp_r, smp_nxt;
  logic [CNT_W-1:0]     entry_count_r;
  logic [WEIGHT_W-1:0]  raw_r, m_r;
  logic [31:0]          prod_r;
  logic [WEIGHT_W-1:0]  q_r;
  logic [WEIGHT_W-1:0]  rest_r;
  logic [IDX_W-1:0]     idx_r;
  logic [IDX_W-1:0]     winner_r;
  logic                 hit_r;

  logic                 sample_fire, write_fire, last_sample;
  logic [WEIGHT_W-1:0]  acc_or;
  logic [31:0]          qsum;
  logic [CNT_W-1:0]     limit;
  logic [IDX_W-1:0]     rd_addr;
  logic [WEIGHT_W-1:0]  rd_weight;

  // weight table
  nwld_ram #(
    .WIDTH (WEIGHT_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .wr_en   (write_fire),
    .wr_addr (in_item.entry_index),
    .wr_data (in_item.entry_weight),
    .rd_addr (rd_addr),
    .rd_data (rd_weight)
  );

  // item decode and noise packing
  always_comb begin
    sample_fire = cmd.accept && (in_item.opcode == OP_SAMPLE);
    write_fire  = cmd.accept && (in_item.opcode == OP_WRITE);
    last_sample = (smp_r == LAST_SAMPLE);
    acc_or      = acc_r | (WEIGHT_W'(in_item.noise_sample[1:0]) << {smp_r, 1'b0});
    acc_nxt     = acc_r;
    smp_nxt     = smp_r;
    if (sample_fire) begin
      if (last_sample) begin
        acc_nxt = '0;
        smp_nxt = '0;
      end else begin
        acc_nxt = acc_or;
        smp_nxt = smp_r + SMP_CNT_W'(1);
      end
    end
  end

  // divide by 65535 as (x + (x >> 16) + 1) >> 16, exact for x below 2^32 - 2^16
  always_comb begin
    qsum    = prod_r + 32'(prod_r[31:16]) + 32'd1;
    limit   = (entry_count_r > LIMIT_MAX) ? LIMIT_MAX : entry_count_r;
    rd_addr = cmd.walk_step ? (idx_r + IDX_W'(1)) : '0;
  end

  // status to controller
  always_comb begin
    sts.draw_go    = sample_fire && last_sample;
    sts.limit_zero = (limit == '0);
    sts.walk_hit   = (rest_r < rd_weight);
    sts.walk_last  = ({1'b0, idx_r} + CNT_W'(1)) == limit;
  end

  // control state: sample packing and configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r         <= '0;
      smp_r         <= '0;
      entry_count_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      smp_r <= smp_nxt;
      if (cfg_we) begin
        entry_count_r <= cfg_data;
      end
    end
  end

  // draw datapath registers
  always_ff @(posedge clk) begin
    if (sample_fire && last_sample) begin
      raw_r <= acc_or;
      m_r   <= in_item.total_weight - WEIGHT_W'(1);
    end
    // product plus half the divisor, rounds the quotient
    if (cmd.mul) begin
      prod_r <= raw_r * m_r + ROUND_HALF;
    end
    if (cmd.div) begin
      q_r <= qsum[31:16];
    end
    if (cmd.walk_init) begin
      rest_r   <= q_r;
      idx_r    <= '0;
      winner_r <= '0;
      hit_r    <= 1'b0;
    end
    // one entry per cycle, next entry read ahead
    if (cmd.walk_step) begin
      if (sts.walk_hit) begin
        winner_r <= idx_r;
        hit_r    <= 1'b1;
      end else begin
        rest_r <= rest_r - rd_weight;
        idx_r  <= idx_r + IDX_W'(1);
      end
    end
  end

  assign out_item.winner_index = winner_r;
  assign out_item.drawn_value  = q_r;
  assign out_item.matched      = hit_r;

endmodule

// ===== design/noise_weighted_lottery_draw_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// noise_weighted_lottery_draw_unit
// Roulette-wheel selection over a 64-entry weight table driven by noise bits.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats are taken on start while busy is low. A write beat stores a
//   weight in the table; a sample beat packs two noise bits. Both give no
//   result. The eighth sample starts a draw: multiply, divide by 65535,
//   walk setup, then one walk step per table entry visited (up to
//   min(entry_count, 64)), then the result strobe. busy stays high for
//   the whole draw; the single table read port lets the walk take one
//   entry per cycle.
//   The result beat appears on out_item for exactly one cycle with
//   out_valid high; the receiver must take it then, it cannot stall.
//   entry_count is written on the cfg channel, ready only while idle.
//   Reset clears the sample count, the packed noise and entry_count; table
//   contents are undefined until written.
// ----------------------------------------------------------------------------
module noise_weighted_lottery_draw_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  nwld_pkg::in_item_t         in_item,
  output logic                       out_valid,
  output nwld_pkg::out_item_t        out_item,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [nwld_pkg::CNT_W-1:0] cfg_data
);
  import nwld_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // controller
  nwld_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .sts       (sts),
    .cmd       (cmd),
    .busy      (busy),
    .cfg_ready (cfg_ready),
    .out_valid (out_valid)
  );

  // datapath
  nwld_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_item  (in_item),
    .cmd      (cmd),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_data (cfg_data),
    .sts      (sts),
    .out_item (out_item)
  );

  // a result only comes out of a draw in progress
  a_out_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while idle");

  // the strobe lasts one cycle and the block is idle after it
  a_out_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> (!out_valid && !busy))
    else $error("result strobe longer than one cycle");

  // a miss reports entry zero
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.matched) |-> (out_item.winner_index == '0))
    else $error("miss with nonzero winner index");

  // configuration only while idle
  a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ready |-> !busy)
    else $error("configuration ready during a draw");

endmodule
